[rtl/core/cor_pkg.sv]
// cor_pkg: shared types, register codes and constants for the channel occupancy ranker
// used by cor_cfg and channel_occupancy_ranker; no dependencies
`timescale 1ns / 1ps

package cor_pkg;

  typedef struct packed {
    logic signed [7:0] strong_rssi_threshold;
    logic signed [7:0] safe_rssi_floor;
    logic [7:0]        portal_grade_code;
    logic [7:0]        redirect_result_code;
    logic [7:0]        intercept_result_code;
  } cfg_t;

  typedef enum logic [2:0] {
    REG_STRONG_RSSI    = 3'd0,
    REG_SAFE_RSSI      = 3'd1,
    REG_PORTAL_GRADE   = 3'd2,
    REG_REDIRECT_CODE  = 3'd3,
    REG_INTERCEPT_CODE = 3'd4
  } reg_idx_t;

  localparam logic signed [7:0] STRONG_RSSI_RESET    = -8'sd70;
  localparam logic signed [7:0] SAFE_RSSI_RESET      = -8'sd85;
  localparam logic [7:0]        PORTAL_GRADE_RESET   = 8'd0;
  localparam logic [7:0]        REDIRECT_CODE_RESET  = 8'd1;
  localparam logic [7:0]        INTERCEPT_CODE_RESET = 8'd2;

  localparam logic [7:0] RISK_NONE     = 8'd101;
  localparam logic [7:0] CONG_CAP      = 8'd100;
  localparam logic [7:0] BEST_DEFAULT  = 8'd1;
  localparam logic [7:0] WORST_DEFAULT = 8'd6;
  localparam logic [7:0] CNT_MAX       = 8'd255;

  function automatic logic [7:0] sat_add(input logic [7:0] a, input logic [1:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {7'd0, b};
    return s[8] ? CNT_MAX : s[7:0];
  endfunction

endpackage

[rtl/core/cor_ram.sv]
// cor_ram: generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module cor_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 14
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/cor_cfg.sv]
// cor_cfg: apb register file holding the signal thresholds and portal codes
// depends on cor_pkg
`timescale 1ns / 1ps

module cor_cfg (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cor_pkg::cfg_t     cfg
);

  logic          wr_en;
  logic [7:0]    rd_val;
  cor_pkg::reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = cor_pkg::reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.strong_rssi_threshold <= cor_pkg::STRONG_RSSI_RESET;
      cfg.safe_rssi_floor       <= cor_pkg::SAFE_RSSI_RESET;
      cfg.portal_grade_code     <= cor_pkg::PORTAL_GRADE_RESET;
      cfg.redirect_result_code  <= cor_pkg::REDIRECT_CODE_RESET;
      cfg.intercept_result_code <= cor_pkg::INTERCEPT_CODE_RESET;
    end else if (wr_en) begin
      case (idx)
        cor_pkg::REG_STRONG_RSSI:    cfg.strong_rssi_threshold <= pwdata[7:0];
        cor_pkg::REG_SAFE_RSSI:      cfg.safe_rssi_floor       <= pwdata[7:0];
        cor_pkg::REG_PORTAL_GRADE:   cfg.portal_grade_code     <= pwdata[7:0];
        cor_pkg::REG_REDIRECT_CODE:  cfg.redirect_result_code  <= pwdata[7:0];
        cor_pkg::REG_INTERCEPT_CODE: cfg.intercept_result_code <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      cor_pkg::REG_STRONG_RSSI:    rd_val = cfg.strong_rssi_threshold;
      cor_pkg::REG_SAFE_RSSI:      rd_val = cfg.safe_rssi_floor;
      cor_pkg::REG_PORTAL_GRADE:   rd_val = cfg.portal_grade_code;
      cor_pkg::REG_REDIRECT_CODE:  rd_val = cfg.redirect_result_code;
      cor_pkg::REG_INTERCEPT_CODE: rd_val = cfg.intercept_result_code;
      default:                     rd_val = 8'd0;
    endcase
  end

  assign prdata = {24'd0, rd_val};

endmodule

[rtl/core/channel_occupancy_ranker.sv]
// channel_occupancy_ranker: per-channel histograms of one scan, ranked on the last network
// depends on cor_pkg, cor_cfg, cor_ram
`timescale 1ns / 1ps

// channel   | handshake            | payload
// ----------+----------------------+------------------------------------------------------
// request   | start / busy         | channel, rssi, risk_score, grade, portal_result,
//           |                      | last_network
// result    | strobe (one cycle)   | rank_position, ranked_channel, last_rank,
//           |                      | total_networks, portal_count, safest_index,
//           |                      | riskiest_index, best_channel, worst_channel,
//           |                      | congestion_score
// config    | apb psel/penable     | paddr, pwdata, prdata (pready tied high)
//
// a request that is not last makes a histogram ram read, then a read-modify-write.
// a last request then runs one summary pass over all channels and, per rank,
// a selection pass over all channels through the one ram read port and comparator;
// results come one per pass, so a last request gives NRES results.
// synchronous reset clears the scan at once through per-channel valid bits.
// busy is high for the whole run; the receiver cannot stall results.

module channel_occupancy_ranker #(
  parameter int NUM_CHANNELS = 14,
  parameter int RANK_LENGTH  = 14
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              start,
  output logic              busy,
  input  logic [7:0]        channel,
  input  logic signed [7:0] rssi,
  input  logic [7:0]        risk_score,
  input  logic [7:0]        grade,
  input  logic [7:0]        portal_result,
  input  logic              last_network,
  output logic              strobe,
  output logic [3:0]        rank_position,
  output logic [3:0]        ranked_channel,
  output logic              last_rank,
  output logic [7:0]        total_networks,
  output logic [7:0]        portal_count,
  output logic [7:0]        safest_index,
  output logic [7:0]        riskiest_index,
  output logic [3:0]        best_channel,
  output logic [3:0]        worst_channel,
  output logic [6:0]        congestion_score
);

  localparam int NRES = (NUM_CHANNELS < RANK_LENGTH) ? NUM_CHANNELS : RANK_LENGTH;
  localparam int AW   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CW   = $clog2(NUM_CHANNELS + 1);

  typedef enum logic [1:0] {IDLE, UPD, SUM, RANK} state_t;

  cor_pkg::cfg_t cfg;

  state_t state;

  // latched request
  logic [AW-1:0]     ch_idx;
  logic              ch_hit;
  logic signed [7:0] rssi_q;
  logic [7:0]        risk_q;
  logic [7:0]        grade_q;
  logic [7:0]        presult_q;
  logic              last_q;

  // scan state
  logic [NUM_CHANNELS-1:0] valid;
  logic [NUM_CHANNELS-1:0] used;
  logic [7:0] net_idx, portal_tally, lowest_risk, highest_risk, safest_pos, riskiest_pos;

  // pass sequencer
  logic [CW-1:0] addr;
  logic [AW-1:0] pidx;
  logic          pv;
  logic [CW-1:0] rk;
  logic [7:0]    minc, maxc, congmax, bestval;
  logic [CW-1:0] best, worst, pick;

  // ram
  logic          ram_we;
  logic [AW-1:0] ram_raddr;
  logic [15:0]   ram_wdata, ram_rdata;

  // combinational
  logic          in_hit;
  logic [7:0]    ch_m1;
  logic [AW-1:0] look_idx;
  logic          ent_ok;
  logic [7:0]    ent_cnt, ent_cong;
  logic          strong_hit;
  logic          step_go, pass_done;
  logic [CW-1:0] pidx_p1, pick_f, pick_m1;
  logic [7:0]    rk_ext, pick_ext, best_ext, worst_ext, cong_cap;
  logic          portal_hit;

  cor_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cor_ram #(
    .WIDTH (16),
    .DEPTH (NUM_CHANNELS)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ch_idx),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy = (state != IDLE);

  always_comb begin
    in_hit    = (channel >= 8'd1) && (channel <= 8'(NUM_CHANNELS));
    ch_m1     = channel - 8'd1;
    ram_raddr = (state == IDLE) ? ch_m1[AW-1:0] : addr[AW-1:0];

    // an entry never written this scan reads as zero
    look_idx = (state == UPD) ? ch_idx : pidx;
    ent_ok   = valid[look_idx];
    ent_cnt  = ent_ok ? ram_rdata[15:8] : 8'd0;
    ent_cong = ent_ok ? ram_rdata[7:0]  : 8'd0;

    strong_hit = rssi_q > cfg.strong_rssi_threshold;
    ram_we     = (state == UPD) && ch_hit;
    ram_wdata  = {cor_pkg::sat_add(ent_cnt, 2'd1),
                  cor_pkg::sat_add(ent_cong, strong_hit ? 2'd2 : 2'd1)};

    portal_hit = (grade_q == cfg.portal_grade_code) ||
                 (presult_q == cfg.redirect_result_code) ||
                 (presult_q == cfg.intercept_result_code);

    step_go   = addr < CW'(NUM_CHANNELS);
    pass_done = !step_go && !pv;
    pidx_p1   = CW'(pidx) + CW'(1);

    // no pickable channel left: fall back to position+1
    pick_f  = (pick == '0) ? (rk + CW'(1)) : pick;
    pick_m1 = pick_f - CW'(1);

    rk_ext    = 8'(rk);
    pick_ext  = 8'(pick_f);
    best_ext  = (minc == cor_pkg::CNT_MAX) ? cor_pkg::BEST_DEFAULT : 8'(best);
    worst_ext = (maxc == 8'd0) ? cor_pkg::WORST_DEFAULT : 8'(worst);
    cong_cap  = (congmax > cor_pkg::CONG_CAP) ? cor_pkg::CONG_CAP : congmax;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      valid        <= '0;
      used         <= '0;
      net_idx      <= 8'd0;
      portal_tally <= 8'd0;
      lowest_risk  <= cor_pkg::RISK_NONE;
      highest_risk <= 8'd0;
      safest_pos   <= 8'd0;
      riskiest_pos <= 8'd0;
      addr         <= '0;
      pv           <= 1'b0;
      rk           <= '0;
      strobe       <= 1'b0;
    end else begin
      strobe <= (state == RANK) && pass_done;
      case (state)
        IDLE: begin
          if (start) begin
            ch_idx    <= ch_m1[AW-1:0];
            ch_hit    <= in_hit;
            rssi_q    <= rssi;
            risk_q    <= risk_score;
            grade_q   <= grade;
            presult_q <= portal_result;
            last_q    <= last_network;
            state     <= UPD;
          end
        end

        UPD: begin
          if (ch_hit) begin
            valid[ch_idx] <= 1'b1;
          end
          if (portal_hit) begin
            portal_tally <= cor_pkg::sat_add(portal_tally, 2'd1);
          end
          if ((rssi_q >= cfg.safe_rssi_floor) && (risk_q < lowest_risk)) begin
            lowest_risk <= risk_q;
            safest_pos  <= net_idx;
          end
          if (risk_q > highest_risk) begin
            highest_risk <= risk_q;
            riskiest_pos <= net_idx;
          end
          net_idx <= cor_pkg::sat_add(net_idx, 2'd1);
          if (last_q) begin
            state   <= SUM;
            addr    <= '0;
            pv      <= 1'b0;
            minc    <= cor_pkg::CNT_MAX;
            maxc    <= 8'd0;
            congmax <= 8'd0;
            best    <= '0;
            worst   <= '0;
          end else begin
            state <= IDLE;
          end
        end

        SUM: begin
          if (step_go) begin
            pidx <= addr[AW-1:0];
            pv   <= 1'b1;
            addr <= addr + CW'(1);
          end else begin
            pv <= 1'b0;
          end
          if (pv) begin
            if (ent_cnt > maxc) begin
              maxc  <= ent_cnt;
              worst <= pidx_p1;
            end
            if ((ent_cnt < minc) && (ent_cnt != 8'd0)) begin
              minc <= ent_cnt;
              best <= pidx_p1;
            end
            if (ent_cong > congmax) begin
              congmax <= ent_cong;
            end
          end
          if (pass_done) begin
            state   <= RANK;
            addr    <= '0;
            rk      <= '0;
            used    <= '0;
            pick    <= '0;
            bestval <= cor_pkg::CNT_MAX;
          end
        end

        RANK: begin
          if (step_go) begin
            pidx <= addr[AW-1:0];
            pv   <= 1'b1;
            addr <= addr + CW'(1);
          end else begin
            pv <= 1'b0;
          end
          // saturated channels never win since bestval starts at the maximum count
          if (pv && !used[pidx] && (ent_cnt < bestval)) begin
            bestval <= ent_cnt;
            pick    <= pidx_p1;
          end
          if (pass_done) begin
            used[pick_m1[AW-1:0]] <= 1'b1;
            rank_position    <= rk_ext[3:0];
            ranked_channel   <= pick_ext[3:0];
            last_rank        <= (rk == CW'(NRES - 1));
            total_networks   <= net_idx;
            portal_count     <= portal_tally;
            safest_index     <= safest_pos;
            riskiest_index   <= riskiest_pos;
            best_channel     <= best_ext[3:0];
            worst_channel    <= worst_ext[3:0];
            congestion_score <= cong_cap[6:0];
            addr             <= '0;
            pick             <= '0;
            bestval          <= cor_pkg::CNT_MAX;
            if (rk == CW'(NRES - 1)) begin
              // scan finished: clear for the next one
              state        <= IDLE;
              valid        <= '0;
              net_idx      <= 8'd0;
              portal_tally <= 8'd0;
              lowest_risk  <= cor_pkg::RISK_NONE;
              highest_risk <= 8'd0;
              safest_pos   <= 8'd0;
              riskiest_pos <= 8'd0;
            end else begin
              rk <= rk + CW'(1);
            end
          end
        end

        default: state <= IDLE;
      endcase
    end
  end

endmodule
